// File: design/ddm_pkg.sv
package ddm_pkg;

    localparam int AXIS_W  = 11;
    localparam int WHEEL_W = 13;
    localparam int PWM_W   = 12;
    localparam int GAIN_W  = 9;
    localparam int CFG_W   = 10;
    localparam int PROD_W  = 23;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic signed [AXIS_W:0]  THROTTLE_KNEE = 12'sd500;
    localparam logic signed [AXIS_W:0]  THROTTLE_MAX  = 12'sd999;
    localparam logic signed [WHEEL_W-1:0] PIVOT_LIMIT = 13'sd50;
    localparam logic [GAIN_W-1:0]       Q8_ONE        = 9'd256;

    localparam logic [GAIN_W-1:0] SMOOTH_GAIN_RST = 9'd64;
    localparam logic [CFG_W-1:0]  DEAD_BAND_RST   = 10'd55;
    localparam logic [CFG_W-1:0]  PWM_OFFSET_RST  = 10'd200;
    localparam logic [CFG_W-1:0]  TURRET_THR_RST  = 10'd200;

    typedef enum logic [1:0] {
        REG_SMOOTH_GAIN = 2'd0,
        REG_DEAD_BAND   = 2'd1,
        REG_PWM_OFFSET  = 2'd2,
        REG_TURRET_THR  = 2'd3
    } reg_idx_t;

    // one classified word between front and back
    typedef struct packed {
        logic signed [WHEEL_W-1:0] left_wheel;
        logic signed [WHEEL_W-1:0] right_wheel;
        logic                      tilt_en;
        logic                      tilt_neg;
        logic                      pan_en;
        logic                      pan_neg;
    } item_t;

    // signed q8 product divided by 256, truncated toward zero
    function automatic logic signed [PROD_W-9:0] q8_trunc(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        adj = p + (p[PROD_W-1] ? 23'sd255 : 23'sd0);
        return adj[PROD_W-1:8];
    endfunction

endpackage

// File: design/ddm_front.sv
module ddm_front (
    input  logic signed [ddm_pkg::AXIS_W-1:0] v_left,
    input  logic signed [ddm_pkg::AXIS_W-1:0] h_left,
    input  logic signed [ddm_pkg::AXIS_W-1:0] v_right,
    input  logic signed [ddm_pkg::AXIS_W-1:0] h_right,
    input  logic        [ddm_pkg::CFG_W-1:0]  turret_thr,
    output ddm_pkg::item_t                    item
);

    logic signed [ddm_pkg::WHEEL_W-1:0] hl3, hr3, steer, pan_ax, thr_w, throttle;
    logic signed [ddm_pkg::WHEEL_W-1:0] vr_w, vl_w;

    always_comb begin
        // scale by 3/2 rounding toward zero
        hl3    = ddm_pkg::WHEEL_W'(h_left) * 13'sd3;
        hr3    = ddm_pkg::WHEEL_W'(h_right) * 13'sd3;
        steer  = (hl3 + (hl3[ddm_pkg::WHEEL_W-1] ? 13'sd1 : 13'sd0)) >>> 1;
        pan_ax = (hr3 + (hr3[ddm_pkg::WHEEL_W-1] ? 13'sd1 : 13'sd0)) >>> 1;
        thr_w  = $signed({3'b000, turret_thr});
        vr_w   = ddm_pkg::WHEEL_W'(v_right);
        vl_w   = ddm_pkg::WHEEL_W'(v_left);

        item.tilt_en  = (vr_w > thr_w) || (vr_w < -thr_w);
        item.tilt_neg = vr_w < -thr_w;
        item.pan_en   = (pan_ax > thr_w) || (pan_ax < -thr_w);
        item.pan_neg  = pan_ax < -thr_w;

        if (vl_w > ddm_pkg::WHEEL_W'(ddm_pkg::THROTTLE_KNEE)) begin
            throttle = ddm_pkg::WHEEL_W'(ddm_pkg::THROTTLE_MAX);
        end else if (vl_w < -ddm_pkg::WHEEL_W'(ddm_pkg::THROTTLE_KNEE)) begin
            throttle = -ddm_pkg::WHEEL_W'(ddm_pkg::THROTTLE_MAX);
        end else begin
            throttle = vl_w <<< 1;
        end

        // forward, reverse and pivot mixing; zero steering takes the left branch
        if (throttle > 13'sd0) begin
            if (steer > 13'sd0) begin
                item.right_wheel = throttle - steer;
                item.left_wheel  = throttle;
            end else begin
                item.left_wheel  = throttle + steer;
                item.right_wheel = throttle;
            end
        end else if (throttle < -ddm_pkg::PIVOT_LIMIT) begin
            if (steer > 13'sd0) begin
                item.right_wheel = throttle + steer;
                item.left_wheel  = throttle;
            end else begin
                item.left_wheel  = throttle - steer;
                item.right_wheel = throttle;
            end
        end else begin
            if (steer > 13'sd0) begin
                item.right_wheel = throttle;
                item.left_wheel  = throttle + steer;
            end else begin
                item.right_wheel = throttle - steer;
                item.left_wheel  = throttle;
            end
        end
    end

endmodule

// File: design/ddm_queue.sv
module ddm_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_en,
    input  ddm_pkg::item_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output ddm_pkg::item_t rd_data,
    output logic           not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ddm_pkg::item_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = count_reg == FULL_CNT;
    assign not_empty = count_reg != '0;
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/ddm_back.sv
module ddm_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  ddm_pkg::item_t                    q_data,
    output logic                              q_pop,
    input  logic [ddm_pkg::GAIN_W-1:0]        smooth_gain,
    input  logic [ddm_pkg::CFG_W-1:0]         dead_band,
    input  logic [ddm_pkg::CFG_W-1:0]         pwm_offset,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ddm_pkg::PWM_W-1:0]         m_left_pwm,
    output logic [ddm_pkg::PWM_W-1:0]         m_right_pwm,
    output logic                              m_left_dir,
    output logic                              m_right_dir,
    output logic                              m_tilt_enable,
    output logic                              m_tilt_dir,
    output logic                              m_pan_enable,
    output logic                              m_pan_dir
);

    localparam int W = ddm_pkg::WHEEL_W;

    logic                 valid_reg;
    logic [ddm_pkg::PWM_W-1:0] lpwm_reg, rpwm_reg;
    logic                 tilt_en_reg, pan_en_reg;
    logic signed [W-1:0]  prev_l_reg, prev_r_reg;
    logic                 ldir_reg, rdir_reg, tdir_reg, pdir_reg;

    logic [ddm_pkg::GAIN_W-1:0] g, g_inv;
    logic signed [ddm_pkg::PROD_W-1:0] pl_new, pl_old, pr_new, pr_old;
    logic signed [ddm_pkg::PROD_W-9:0] sum_l, sum_r;
    logic signed [W-1:0]  sl, sr, db_s;
    logic [W-1:0]         mag_l, mag_r, lpwm_w, rpwm_w;
    logic                 ldir_next, rdir_next, tdir_next, pdir_next;

    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        g     = (smooth_gain > ddm_pkg::Q8_ONE) ? ddm_pkg::Q8_ONE : smooth_gain;
        g_inv = ddm_pkg::Q8_ONE - g;
        pl_new = ddm_pkg::PROD_W'(q_data.left_wheel)  * $signed({1'b0, g});
        pl_old = ddm_pkg::PROD_W'(prev_l_reg)         * $signed({1'b0, g_inv});
        pr_new = ddm_pkg::PROD_W'(q_data.right_wheel) * $signed({1'b0, g});
        pr_old = ddm_pkg::PROD_W'(prev_r_reg)         * $signed({1'b0, g_inv});
        sum_l = ddm_pkg::q8_trunc(pl_new) + ddm_pkg::q8_trunc(pl_old);
        sum_r = ddm_pkg::q8_trunc(pr_new) + ddm_pkg::q8_trunc(pr_old);
        sl = sum_l[W-1:0];
        sr = sum_r[W-1:0];

        db_s  = $signed({3'b000, dead_band});
        mag_l = sl[W-1] ? W'(-sl) : W'(sl);
        mag_r = sr[W-1] ? W'(-sr) : W'(sr);
        lpwm_w = (mag_l > W'(dead_band)) ? mag_l + W'(pwm_offset) : '0;
        rpwm_w = (mag_r > W'(dead_band)) ? mag_r + W'(pwm_offset) : '0;

        // direction holds inside the band; equal to the band counts as forward
        ldir_next = (sl >= db_s) ? 1'b1 : ((sl < -db_s) ? 1'b0 : ldir_reg);
        rdir_next = (sr >= db_s) ? 1'b1 : ((sr < -db_s) ? 1'b0 : rdir_reg);
        tdir_next = q_data.tilt_en ? q_data.tilt_neg : tdir_reg;
        pdir_next = q_data.pan_en ? q_data.pan_neg : pdir_reg;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            lpwm_reg    <= lpwm_w[ddm_pkg::PWM_W-1:0];
            rpwm_reg    <= rpwm_w[ddm_pkg::PWM_W-1:0];
            tilt_en_reg <= q_data.tilt_en;
            pan_en_reg  <= q_data.pan_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            ldir_reg   <= 1'b0;
            rdir_reg   <= 1'b0;
            tdir_reg   <= 1'b0;
            pdir_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                valid_reg  <= 1'b1;
                prev_l_reg <= sl;
                prev_r_reg <= sr;
                ldir_reg   <= ldir_next;
                rdir_reg   <= rdir_next;
                tdir_reg   <= tdir_next;
                pdir_reg   <= pdir_next;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = valid_reg;
    assign m_left_pwm    = lpwm_reg;
    assign m_right_pwm   = rpwm_reg;
    assign m_left_dir    = ldir_reg;
    assign m_right_dir   = rdir_reg;
    assign m_tilt_enable = tilt_en_reg;
    assign m_tilt_dir    = tdir_reg;
    assign m_pan_enable  = pan_en_reg;
    assign m_pan_dir     = pdir_reg;

endmodule

// File: design/differential_drive_mixer_top.sv
// path: an accepted word is written into the queue, then registered in the back end output stage
// throughput: one word per cycle while m_ready holds, set by the smoothing unit in the back end
// a QUEUE_DEPTH-entry queue between front end and back end absorbs output stalls
// reset: synchronous active-low aresetn clears the queue, output valid, smoothed wheel
// state and direction bits, and loads the default configuration registers
module differential_drive_mixer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [ddm_pkg::AXIS_W-1:0] s_v_left,
    input  logic signed [ddm_pkg::AXIS_W-1:0] s_h_left,
    input  logic signed [ddm_pkg::AXIS_W-1:0] s_v_right,
    input  logic signed [ddm_pkg::AXIS_W-1:0] s_h_right,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ddm_pkg::PWM_W-1:0]         m_left_pwm,
    output logic [ddm_pkg::PWM_W-1:0]         m_right_pwm,
    output logic                              m_left_dir,
    output logic                              m_right_dir,
    output logic                              m_tilt_enable,
    output logic                              m_tilt_dir,
    output logic                              m_pan_enable,
    output logic                              m_pan_dir,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ddm_pkg::ADDR_W-1:0]        paddr,
    input  logic [ddm_pkg::DATA_W-1:0]        pwdata,
    output logic [ddm_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    logic [ddm_pkg::GAIN_W-1:0] smooth_gain_reg;
    logic [ddm_pkg::CFG_W-1:0]  dead_band_reg, pwm_offset_reg, turret_thr_reg;
    ddm_pkg::reg_idx_t          reg_sel;

    ddm_pkg::item_t front_item, q_item;
    logic           q_full, q_valid, q_pop, push;

    assign pready  = 1'b1;
    assign reg_sel = ddm_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_gain_reg <= ddm_pkg::SMOOTH_GAIN_RST;
            dead_band_reg   <= ddm_pkg::DEAD_BAND_RST;
            pwm_offset_reg  <= ddm_pkg::PWM_OFFSET_RST;
            turret_thr_reg  <= ddm_pkg::TURRET_THR_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                ddm_pkg::REG_SMOOTH_GAIN: smooth_gain_reg <= pwdata[ddm_pkg::GAIN_W-1:0];
                ddm_pkg::REG_DEAD_BAND:   dead_band_reg   <= pwdata[ddm_pkg::CFG_W-1:0];
                ddm_pkg::REG_PWM_OFFSET:  pwm_offset_reg  <= pwdata[ddm_pkg::CFG_W-1:0];
                ddm_pkg::REG_TURRET_THR:  turret_thr_reg  <= pwdata[ddm_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            ddm_pkg::REG_SMOOTH_GAIN: prdata = ddm_pkg::DATA_W'(smooth_gain_reg);
            ddm_pkg::REG_DEAD_BAND:   prdata = ddm_pkg::DATA_W'(dead_band_reg);
            ddm_pkg::REG_PWM_OFFSET:  prdata = ddm_pkg::DATA_W'(pwm_offset_reg);
            ddm_pkg::REG_TURRET_THR:  prdata = ddm_pkg::DATA_W'(turret_thr_reg);
            default:                  prdata = '0;
        endcase
    end

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    ddm_front u_front (
        .v_left     (s_v_left),
        .h_left     (s_h_left),
        .v_right    (s_v_right),
        .h_right    (s_h_right),
        .turret_thr (turret_thr_reg),
        .item       (front_item)
    );

    ddm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (push),
        .wr_data   (front_item),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_item),
        .not_empty (q_valid)
    );

    ddm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_item),
        .q_pop         (q_pop),
        .smooth_gain   (smooth_gain_reg),
        .dead_band     (dead_band_reg),
        .pwm_offset    (pwm_offset_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_pwm    (m_left_pwm),
        .m_right_pwm   (m_right_pwm),
        .m_left_dir    (m_left_dir),
        .m_right_dir   (m_right_dir),
        .m_tilt_enable (m_tilt_enable),
        .m_tilt_dir    (m_tilt_dir),
        .m_pan_enable  (m_pan_enable),
        .m_pan_dir     (m_pan_dir)
    );

endmodule

// File: tb/sv/differential_drive_mixer_top_tb.sv
module differential_drive_mixer_top_tb;

    typedef struct packed {
        logic signed [ddm_pkg::AXIS_W-1:0] v_left;
        logic signed [ddm_pkg::AXIS_W-1:0] h_left;
        logic signed [ddm_pkg::AXIS_W-1:0] v_right;
        logic signed [ddm_pkg::AXIS_W-1:0] h_right;
    } stick_word_t;

    typedef struct packed {
        logic [ddm_pkg::PWM_W-1:0] left_pwm;
        logic [ddm_pkg::PWM_W-1:0] right_pwm;
        logic                      left_dir;
        logic                      right_dir;
        logic                      tilt_enable;
        logic                      tilt_dir;
        logic                      pan_enable;
        logic                      pan_dir;
    } drive_cmd_t;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_KNOWN,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        stick_word_t               word;
        ddm_pkg::reg_idx_t         idx;
        logic [ddm_pkg::CFG_W-1:0] value;
        drive_cmd_t                want;
    } plan_row_t;

    localparam logic signed [ddm_pkg::AXIS_W-1:0] AXIS_MIN = 11'sh400;
    localparam int PLAN_LEN = 29;
    localparam int SEGMENTS = 9;
    localparam int SEG_WORDS = 150;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [ddm_pkg::AXIS_W-1:0] s_v_left;
    logic signed [ddm_pkg::AXIS_W-1:0] s_h_left;
    logic signed [ddm_pkg::AXIS_W-1:0] s_v_right;
    logic signed [ddm_pkg::AXIS_W-1:0] s_h_right;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [ddm_pkg::PWM_W-1:0]         m_left_pwm;
    logic [ddm_pkg::PWM_W-1:0]         m_right_pwm;
    logic                              m_left_dir;
    logic                              m_right_dir;
    logic                              m_tilt_enable;
    logic                              m_tilt_dir;
    logic                              m_pan_enable;
    logic                              m_pan_dir;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [ddm_pkg::ADDR_W-1:0]        paddr;
    logic [ddm_pkg::DATA_W-1:0]        pwdata;
    logic [ddm_pkg::DATA_W-1:0]        prdata;
    logic                              pready;

    // mixer model state and its copy of the registers
    logic [ddm_pkg::GAIN_W-1:0]         gain_cfg;
    logic [ddm_pkg::CFG_W-1:0]          band_cfg;
    logic [ddm_pkg::CFG_W-1:0]          offset_cfg;
    logic [ddm_pkg::CFG_W-1:0]          thr_cfg;
    logic signed [ddm_pkg::WHEEL_W-1:0] kept_left;
    logic signed [ddm_pkg::WHEEL_W-1:0] kept_right;
    logic                               left_held;
    logic                               right_held;
    logic                               tilt_held;
    logic                               pan_held;

    drive_cmd_t cmd_q[$];
    int         fail_count = 0;
    int         src_idle_pct = 12;
    int         rcv_idle_pct = 62;

    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_KNOWN, '{11'sd0, 11'sd0, 11'sd0, 11'sd0}, ddm_pkg::REG_SMOOTH_GAIN, 10'd0, '0},
        '{ROW_KNOWN, '{11'sd1023, 11'sd0, 11'sd1023, 11'sd1023}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '{12'd449, 12'd449, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{ROW_WORD, '{AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0},
        // knee of the throttle curve, turret axes right at the threshold
        '{ROW_WORD, '{11'sd500, 11'sd300, 11'sd200, 11'sd133}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0},
        '{ROW_WORD, '{11'sd501, -11'sd300, 11'sd201, 11'sd134}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0},
        '{ROW_WORD, '{-11'sd500, 11'sd300, -11'sd200, -11'sd133}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0},
        '{ROW_WORD, '{-11'sd501, -11'sd300, -11'sd201, -11'sd134}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0},
        // small reverse throttle falls into the pivot rules; -26 already mixes as reverse
        '{ROW_WORD, '{-11'sd25, 11'sd400, 11'sd0, 11'sd0}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0},
        '{ROW_WORD, '{-11'sd25, -11'sd400, 11'sd0, 11'sd0}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0},
        '{ROW_WORD, '{-11'sd26, 11'sd400, 11'sd0, 11'sd0}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0},
        '{ROW_WORD, '{-11'sd26, 11'sd0, 11'sd0, 11'sd0}, ddm_pkg::REG_SMOOTH_GAIN, 10'd0, '0},
        '{ROW_WORD, '{11'sd100, 11'sd0, 11'sd0, 11'sd0}, ddm_pkg::REG_SMOOTH_GAIN, 10'd0, '0},
        '{ROW_WORD, '{11'sd1, 11'sd1023, 11'sd0, 11'sd0}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0},
        '{ROW_CFG, '0, ddm_pkg::REG_SMOOTH_GAIN, 10'd256, '0},
        // wheel lands exactly on the dead band
        '{ROW_WORD, '{11'sd0, 11'sd37, 11'sd0, 11'sd0}, ddm_pkg::REG_SMOOTH_GAIN, 10'd0, '0},
        '{ROW_WORD, '{11'sd0, -11'sd37, 11'sd0, 11'sd0}, ddm_pkg::REG_SMOOTH_GAIN, 10'd0, '0},
        '{ROW_CFG, '0, ddm_pkg::REG_SMOOTH_GAIN, 10'd511, '0},
        '{ROW_WORD, '{-11'sd1023, 11'sd1023, 11'sd1023, -11'sd1023},
          ddm_pkg::REG_SMOOTH_GAIN, 10'd0, '0},
        '{ROW_CFG, '0, ddm_pkg::REG_DEAD_BAND, 10'd0, '0},
        '{ROW_CFG, '0, ddm_pkg::REG_PWM_OFFSET, 10'd1023, '0},
        '{ROW_CFG, '0, ddm_pkg::REG_TURRET_THR, 10'd0, '0},
        '{ROW_WORD, '{11'sd0, 11'sd0, 11'sd0, 11'sd0}, ddm_pkg::REG_SMOOTH_GAIN, 10'd0, '0},
        '{ROW_WORD, '{11'sd0, 11'sd1, -11'sd1, 11'sd1}, ddm_pkg::REG_SMOOTH_GAIN, 10'd0, '0},
        '{ROW_CFG, '0, ddm_pkg::REG_SMOOTH_GAIN, 10'd0, '0},
        '{ROW_CFG, '0, ddm_pkg::REG_DEAD_BAND, 10'd1023, '0},
        '{ROW_CFG, '0, ddm_pkg::REG_PWM_OFFSET, 10'd0, '0},
        '{ROW_CFG, '0, ddm_pkg::REG_TURRET_THR, 10'd1023, '0},
        '{ROW_WORD, '{11'sd1023, 11'sd1023, 11'sd1023, 11'sd1023}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0},
        '{ROW_WORD, '{AXIS_MIN, 11'sd512, -11'sd1023, -11'sd683}, ddm_pkg::REG_SMOOTH_GAIN,
          10'd0, '0}
    };

    differential_drive_mixer_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_v_left      (s_v_left),
        .s_h_left      (s_h_left),
        .s_v_right     (s_v_right),
        .s_h_right     (s_h_right),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_pwm    (m_left_pwm),
        .m_right_pwm   (m_right_pwm),
        .m_left_dir    (m_left_dir),
        .m_right_dir   (m_right_dir),
        .m_tilt_enable (m_tilt_enable),
        .m_tilt_dir    (m_tilt_dir),
        .m_pan_enable  (m_pan_enable),
        .m_pan_dir     (m_pan_dir),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("differential_drive_mixer_top: mismatch");
        $finish;
    end

    // -1, 0 or 1 for a turret axis against the threshold
    function automatic int turret_cmd(input int axis);
        if (axis > int'(thr_cfg)) return 1;
        if (axis < -int'(thr_cfg)) return -1;
        return 0;
    endfunction

    function automatic int smooth_wheel(input int target, input int kept);
        int g;
        int one;
        one = int'(ddm_pkg::Q8_ONE);
        g = (gain_cfg > ddm_pkg::Q8_ONE) ? one : int'(gain_cfg);
        return (target * g) / one + (kept * (one - g)) / one;
    endfunction

    function automatic logic [ddm_pkg::PWM_W-1:0] wheel_pwm(input int wheel);
        int mag;
        mag = (wheel < 0) ? -wheel : wheel;
        if (mag > int'(band_cfg)) return ddm_pkg::PWM_W'(mag + int'(offset_cfg));
        return '0;
    endfunction

    function automatic logic wheel_dir(input int wheel, input logic held);
        if (wheel >= int'(band_cfg)) return 1'b1;
        if (wheel < -int'(band_cfg)) return 1'b0;
        return held;
    endfunction

    // throttle shaping, arcade mix, smoothing, dead band and turret commands for one word
    function automatic drive_cmd_t mix_drive(input stick_word_t w);
        int         throttle;
        int         steer;
        int         tilt;
        int         pan;
        int         lw;
        int         rw;
        int         sl;
        int         sr;
        drive_cmd_t r;
        throttle = $signed(w.v_left);
        steer = $signed(w.h_left);
        steer = (steer * 3) / 2;
        tilt = turret_cmd($signed(w.v_right));
        pan = $signed(w.h_right);
        pan = turret_cmd((pan * 3) / 2);

        if (throttle > int'(ddm_pkg::THROTTLE_KNEE)) throttle = int'(ddm_pkg::THROTTLE_MAX);
        else if (throttle < -int'(ddm_pkg::THROTTLE_KNEE)) throttle = -int'(ddm_pkg::THROTTLE_MAX);
        else throttle = 2 * throttle;

        if (throttle > 0) begin
            if (steer > 0) begin
                rw = throttle - steer;
                lw = throttle;
            end else begin
                lw = throttle + steer;
                rw = throttle;
            end
        end else if (throttle < -int'(ddm_pkg::PIVOT_LIMIT)) begin
            if (steer > 0) begin
                rw = throttle + steer;
                lw = throttle;
            end else begin
                lw = throttle - steer;
                rw = throttle;
            end
        end else begin
            // pivot: zero steering counts as steering left
            if (steer > 0) begin
                rw = throttle;
                lw = throttle + steer;
            end else begin
                rw = throttle - steer;
                lw = throttle;
            end
        end

        sl = smooth_wheel(lw, kept_left);
        sr = smooth_wheel(rw, kept_right);
        kept_left = ddm_pkg::WHEEL_W'(sl);
        kept_right = ddm_pkg::WHEEL_W'(sr);
        left_held = wheel_dir(sl, left_held);
        right_held = wheel_dir(sr, right_held);
        if (tilt < 0) tilt_held = 1'b1;
        else if (tilt > 0) tilt_held = 1'b0;
        if (pan < 0) pan_held = 1'b1;
        else if (pan > 0) pan_held = 1'b0;

        r.left_pwm = wheel_pwm(sl);
        r.right_pwm = wheel_pwm(sr);
        r.left_dir = left_held;
        r.right_dir = right_held;
        r.tilt_enable = (tilt != 0);
        r.tilt_dir = tilt_held;
        r.pan_enable = (pan != 0);
        r.pan_dir = pan_held;
        return r;
    endfunction

    function automatic logic signed [ddm_pkg::AXIS_W-1:0] pick_axis();
        if ($urandom_range(0, 7) != 0) return ddm_pkg::AXIS_W'($urandom_range(0, 2047));
        case ($urandom_range(0, 7))
            0: return AXIS_MIN;
            1: return 11'sd1023;
            2: return -11'sd1023;
            3: return 11'sd0;
            4: return ddm_pkg::AXIS_W'($urandom_range(0, 1) ? 500 + $urandom_range(0, 1)
                                                              : -500 - $urandom_range(0, 1));
            5: return ddm_pkg::AXIS_W'(-25 - $urandom_range(0, 1));
            6: return ddm_pkg::AXIS_W'($urandom_range(0, 1) ? 37 : -37);
            default: return ddm_pkg::AXIS_W'($urandom_range(0, 1) ? 133 + $urandom_range(0, 1)
                                                                    : -133 - $urandom_range(0, 1));
        endcase
    endfunction

    task automatic flag_mismatch(input string why, input drive_cmd_t want,
                                 input drive_cmd_t got);
        fail_count++;
        if (fail_count <= 10)
            $display({"%s: want pwm %0d/%0d dir %b%b tilt %b%b pan %b%b, ",
                      "got pwm %0d/%0d dir %b%b tilt %b%b pan %b%b"},
                     why, want.left_pwm, want.right_pwm, want.left_dir, want.right_dir,
                     want.tilt_enable, want.tilt_dir, want.pan_enable, want.pan_dir,
                     got.left_pwm, got.right_pwm, got.left_dir, got.right_dir,
                     got.tilt_enable, got.tilt_dir, got.pan_enable, got.pan_dir);
    endtask

    task automatic write_reg(input ddm_pkg::reg_idx_t idx,
                             input logic [ddm_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            ddm_pkg::REG_SMOOTH_GAIN: gain_cfg = ddm_pkg::GAIN_W'(value);
            ddm_pkg::REG_DEAD_BAND:   band_cfg = ddm_pkg::CFG_W'(value);
            ddm_pkg::REG_PWM_OFFSET:  offset_cfg = ddm_pkg::CFG_W'(value);
            ddm_pkg::REG_TURRET_THR:  thr_cfg = ddm_pkg::CFG_W'(value);
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // hold off the source until every result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge aclk);
    endtask

    task automatic send_word(input stick_word_t w, input bit typed, input drive_cmd_t want);
        drive_cmd_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_v_left <= w.v_left;
        s_h_left <= w.h_left;
        s_v_right <= w.v_right;
        s_h_right <= w.h_right;
        do @(posedge aclk); while (!s_ready);
        predicted = mix_drive(w);
        cmd_q.push_back(typed ? want : predicted);
    endtask

    always @(posedge aclk) begin : result_check
        drive_cmd_t got;
        got = {m_left_pwm, m_right_pwm, m_left_dir, m_right_dir,
               m_tilt_enable, m_tilt_dir, m_pan_enable, m_pan_dir};
        if (aresetn && m_valid && m_ready) begin
            if (cmd_q.size() == 0) begin
                flag_mismatch("unexpected word", '0, got);
            end else if (got !== cmd_q[0]) begin
                flag_mismatch("wrong word", cmd_q[0], got);
                void'(cmd_q.pop_front());
            end else begin
                void'(cmd_q.pop_front());
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    initial begin : stimulus
        stick_word_t w;
        gain_cfg = ddm_pkg::SMOOTH_GAIN_RST;
        band_cfg = ddm_pkg::DEAD_BAND_RST;
        offset_cfg = ddm_pkg::PWM_OFFSET_RST;
        thr_cfg = ddm_pkg::TURRET_THR_RST;
        kept_left = '0;
        kept_right = '0;
        left_held = 1'b0;
        right_held = 1'b0;
        tilt_held = 1'b0;
        pan_held = 1'b0;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_v_left <= '0;
        s_h_left <= '0;
        s_v_right <= '0;
        s_h_right <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                drain_results();
                write_reg(plan[i].idx, ddm_pkg::DATA_W'(plan[i].value));
            end else begin
                send_word(plan[i].word, plan[i].kind == ROW_KNOWN, plan[i].want);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_results();
            case (seg / 3)
                0: begin
                    src_idle_pct = 12;
                    rcv_idle_pct = 62;
                end
                1: begin
                    src_idle_pct = 62;
                    rcv_idle_pct = 12;
                end
                default: begin
                    src_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(ddm_pkg::REG_SMOOTH_GAIN,
                             ddm_pkg::DATA_W'($urandom_range(1, 32)));
                1: write_reg(ddm_pkg::REG_SMOOTH_GAIN,
                             ddm_pkg::DATA_W'($urandom_range(0, 255)));
                2: write_reg(ddm_pkg::REG_SMOOTH_GAIN, ddm_pkg::DATA_W'(256));
                default: write_reg(ddm_pkg::REG_SMOOTH_GAIN,
                                   ddm_pkg::DATA_W'($urandom_range(257, 511)));
            endcase
            // keep the dead band mostly small so the pwm path gets exercised
            write_reg(ddm_pkg::REG_DEAD_BAND,
                      ddm_pkg::DATA_W'($urandom_range(0, 3) == 0 ?
                                       $urandom_range(0, 1023) : $urandom_range(0, 150)));
            write_reg(ddm_pkg::REG_PWM_OFFSET, ddm_pkg::DATA_W'($urandom_range(0, 1023)));
            write_reg(ddm_pkg::REG_TURRET_THR,
                      ddm_pkg::DATA_W'($urandom_range(0, 3) == 0 ?
                                       $urandom_range(0, 1023) : $urandom_range(0, 400)));
            for (int n = 0; n < SEG_WORDS; n++) begin
                w = '{pick_axis(), pick_axis(), pick_axis(), pick_axis()};
                send_word(w, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("differential_drive_mixer_top: match");
        end else begin
            $display("differential_drive_mixer_top: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
design/ddm_pkg.sv
design/ddm_front.sv
design/ddm_queue.sv
design/ddm_back.sv
design/differential_drive_mixer_top.sv
tb/sv/differential_drive_mixer_top_tb.sv
